// File: rtl/core/pfc_pkg.sv
// Shared types and constants for the pixel format converter.
// Format codes, register indexes, lane layout and the divider bundle.
// No dependencies.
`default_nettype none

package pfc_pkg;

    typedef enum logic [2:0] {
        FMT_GRAY8    = 3'd0,
        FMT_RGB555   = 3'd1,
        FMT_RGB565   = 3'd2,
        FMT_RGB888   = 3'd3,
        FMT_RGBA8888 = 3'd4,
        FMT_RGB16    = 3'd5,
        FMT_RGBA16   = 3'd6
    } pfc_fmt_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FMT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_FMT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREMUL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_W_BLUE    = 3'd5;

    localparam int PIX_W  = 64;
    localparam int WORD_W = 32;
    localparam int CH_W   = 16;
    localparam int NUM_W  = 32;
    localparam int REM_W  = 48;
    localparam int SUM_W  = 50;
    localparam int GSH_W  = 58;
    localparam int QUO_W  = 16;
    localparam int WFRAC  = 16;

    localparam int NCOLOR = 3;
    localparam int NLANE  = 4;
    localparam int LANE_R = 0;
    localparam int LANE_G = 1;
    localparam int LANE_B = 2;
    localparam int LANE_A = 3;

    localparam int FRONT_STAGES = 5;
    localparam int DIV_STEPS    = QUO_W;
    localparam int PACK_STAGES  = 1;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + PACK_STAGES;

    localparam logic [CH_W-1:0] MAX5   = 16'd31;
    localparam logic [CH_W-1:0] MAX6   = 16'd63;
    localparam logic [CH_W-1:0] MAX8   = 16'd255;
    localparam logic [CH_W-1:0] MAX16  = 16'd65535;
    localparam logic [CH_W-1:0] DEN565 = 16'd1953;

    localparam logic [CH_W-1:0] RST_W_RED   = 16'd13933;
    localparam logic [CH_W-1:0] RST_W_GREEN = 16'd46871;
    localparam logic [CH_W-1:0] RST_W_BLUE  = 16'd4732;

    typedef struct packed {
        pfc_fmt_t        src_fmt;
        pfc_fmt_t        dst_fmt;
        logic            premul;
        logic [CH_W-1:0] w_red;
        logic [CH_W-1:0] w_green;
        logic [CH_W-1:0] w_blue;
    } pfc_cfg_t;

    typedef struct packed {
        logic [NLANE-1:0][REM_W-1:0] rem;
        logic [NLANE-1:0][QUO_W-1:0] quo;
        logic [NUM_W-1:0]            den;
        logic [CH_W-1:0]             alpha_den;
    } pfc_div_t;

endpackage

`default_nettype wire

// File: rtl/core/pfc_front.sv
// Front end of the converter: unpack, premultiply, channel products,
// gray sum and dividend setup, five register stages. Uses pfc_pkg.
`default_nettype none

module pfc_front import pfc_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire pfc_cfg_t       cfg,
    input  wire logic [PIX_W-1:0] pixel,
    output pfc_div_t            div_out
);

    // stage A: unpack
    logic [NCOLOR-1:0][CH_W-1:0] a_num_next, a_num_reg;
    logic [CH_W-1:0]             a_den_next, a_den_reg;
    logic [CH_W-1:0]             a_an_next, a_an_reg;
    logic [CH_W-1:0]             a_ad_next, a_ad_reg;
    logic                        a_alpha_next, a_alpha_reg;

    // stage B: premultiply
    logic [NCOLOR-1:0][NUM_W-1:0] b_num_next, b_num_reg;
    logic [NUM_W-1:0]             b_den_next, b_den_reg;
    logic [CH_W-1:0]              b_an_reg, b_ad_reg;
    logic                         premul_on;

    // stage C: products
    logic [NCOLOR-1:0][CH_W-1:0]  mul_op;
    logic [CH_W-1:0]              alpha_op;
    logic [NCOLOR-1:0][REM_W-1:0] c_prod_next, c_prod_reg;
    logic [NUM_W-1:0]             c_aprod_next, c_aprod_reg;
    logic [NUM_W-1:0]             c_den_reg;
    logic [CH_W-1:0]              c_ad_reg;

    // stage D: gray sum
    logic [SUM_W-1:0]             d_sum_next, d_sum_reg;
    logic [NCOLOR-1:0][REM_W-1:0] d_prod_reg;
    logic [NUM_W-1:0]             d_aprod_reg;
    logic [NUM_W-1:0]             d_den_reg;
    logic [CH_W-1:0]              d_ad_reg;

    // stage E: dividends
    logic [GSH_W-1:0]             gray_wide;
    logic [GSH_W-1:0]             gray_tmp;
    logic [REM_W-1:0]             gray_x;
    logic [REM_W-1:0]             half_den;
    pfc_div_t                     e_next, e_reg;

    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;

    assign lo = pixel[WORD_W-1:0];
    assign hi = pixel[PIX_W-1:WORD_W];

    always_comb begin
        a_num_next   = '0;
        a_den_next   = 16'd1;
        a_an_next    = 16'd1;
        a_ad_next    = 16'd1;
        a_alpha_next = 1'b0;
        case (cfg.src_fmt)
            FMT_GRAY8: begin
                a_num_next[LANE_R] = CH_W'(lo[7:0]);
                a_num_next[LANE_G] = CH_W'(lo[7:0]);
                a_num_next[LANE_B] = CH_W'(lo[7:0]);
                a_den_next         = MAX8;
            end
            FMT_RGB555: begin
                a_num_next[LANE_R] = CH_W'(lo[14:10]);
                a_num_next[LANE_G] = CH_W'(lo[9:5]);
                a_num_next[LANE_B] = CH_W'(lo[4:0]);
                a_den_next         = MAX5;
            end
            FMT_RGB565: begin
                // common denominator 31 * 63
                a_num_next[LANE_R] = CH_W'(lo[15:11]) * MAX6;
                a_num_next[LANE_G] = CH_W'(lo[10:5]) * MAX5;
                a_num_next[LANE_B] = CH_W'(lo[4:0]) * MAX6;
                a_den_next         = DEN565;
            end
            FMT_RGB888, FMT_RGBA8888: begin
                a_num_next[LANE_R] = CH_W'(lo[23:16]);
                a_num_next[LANE_G] = CH_W'(lo[15:8]);
                a_num_next[LANE_B] = CH_W'(lo[7:0]);
                a_den_next         = MAX8;
                if (cfg.src_fmt == FMT_RGBA8888) begin
                    a_an_next    = CH_W'(lo[31:24]);
                    a_ad_next    = MAX8;
                    a_alpha_next = 1'b1;
                end
            end
            FMT_RGB16, FMT_RGBA16: begin
                a_num_next[LANE_R] = lo[15:0];
                a_num_next[LANE_G] = lo[31:16];
                a_num_next[LANE_B] = hi[15:0];
                a_den_next         = MAX16;
                if (cfg.src_fmt == FMT_RGBA16) begin
                    a_an_next    = hi[31:16];
                    a_ad_next    = MAX16;
                    a_alpha_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign premul_on = cfg.premul && a_alpha_reg;

    always_comb begin
        for (int i = 0; i < NCOLOR; i++) begin
            b_num_next[i] = premul_on ? NUM_W'(a_num_reg[i]) * NUM_W'(a_an_reg)
                                      : NUM_W'(a_num_reg[i]);
        end
        b_den_next = premul_on ? NUM_W'(a_den_reg) * NUM_W'(a_ad_reg)
                               : NUM_W'(a_den_reg);
    end

    // gray uses the weights, color uses the destination channel maximum
    always_comb begin
        mul_op   = '0;
        alpha_op = '0;
        case (cfg.dst_fmt)
            FMT_GRAY8: begin
                mul_op[LANE_R] = cfg.w_red;
                mul_op[LANE_G] = cfg.w_green;
                mul_op[LANE_B] = cfg.w_blue;
            end
            FMT_RGB555: begin
                mul_op[LANE_R] = MAX5;
                mul_op[LANE_G] = MAX5;
                mul_op[LANE_B] = MAX5;
            end
            FMT_RGB565: begin
                mul_op[LANE_R] = MAX5;
                mul_op[LANE_G] = MAX6;
                mul_op[LANE_B] = MAX5;
            end
            FMT_RGB888, FMT_RGBA8888: begin
                mul_op[LANE_R] = MAX8;
                mul_op[LANE_G] = MAX8;
                mul_op[LANE_B] = MAX8;
                alpha_op       = MAX8;
            end
            FMT_RGB16, FMT_RGBA16: begin
                mul_op[LANE_R] = MAX16;
                mul_op[LANE_G] = MAX16;
                mul_op[LANE_B] = MAX16;
                alpha_op       = MAX16;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NCOLOR; i++) begin
            c_prod_next[i] = REM_W'(b_num_reg[i]) * REM_W'(mul_op[i]);
        end
        c_aprod_next = NUM_W'(b_an_reg) * NUM_W'(alpha_op);
    end

    assign d_sum_next = SUM_W'(c_prod_reg[LANE_R]) + SUM_W'(c_prod_reg[LANE_G])
                      + SUM_W'(c_prod_reg[LANE_B]);

    // gray: floor((sum * 255 + den * 2^15) / 2^16), then divided by den
    assign gray_wide = GSH_W'(d_sum_reg);
    assign gray_tmp  = (gray_wide << 8) - gray_wide + (GSH_W'(d_den_reg) << (WFRAC - 1));
    assign gray_x    = REM_W'(gray_tmp[GSH_W-1:WFRAC]);
    assign half_den  = REM_W'(d_den_reg >> 1);

    always_comb begin
        e_next.quo = '0;
        e_next.den = d_den_reg;
        e_next.alpha_den = d_ad_reg;
        for (int i = 0; i < NCOLOR; i++) begin
            e_next.rem[i] = d_prod_reg[i] + half_den;
        end
        if (cfg.dst_fmt == FMT_GRAY8) begin
            e_next.rem[LANE_R] = gray_x;
        end
        e_next.rem[LANE_A] = REM_W'(d_aprod_reg) + REM_W'(d_ad_reg >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_num_reg   <= a_num_next;
            a_den_reg   <= a_den_next;
            a_an_reg    <= a_an_next;
            a_ad_reg    <= a_ad_next;
            a_alpha_reg <= a_alpha_next;

            b_num_reg <= b_num_next;
            b_den_reg <= b_den_next;
            b_an_reg  <= a_an_reg;
            b_ad_reg  <= a_ad_reg;

            c_prod_reg  <= c_prod_next;
            c_aprod_reg <= c_aprod_next;
            c_den_reg   <= b_den_reg;
            c_ad_reg    <= b_ad_reg;

            d_sum_reg   <= d_sum_next;
            d_prod_reg  <= c_prod_reg;
            d_aprod_reg <= c_aprod_reg;
            d_den_reg   <= c_den_reg;
            d_ad_reg    <= c_ad_reg;

            e_reg <= e_next;
        end
    end

    assign div_out = e_reg;

endmodule

`default_nettype wire

// File: rtl/core/pfc_div_step.sv
// One restoring division step for all four lanes, one quotient bit per stage.
// Color lanes divide by den, the alpha lane by alpha_den. Uses pfc_pkg.
`default_nettype none

module pfc_div_step import pfc_pkg::*; #(
    parameter int BIT = QUO_W - 1
) (
    input  wire logic     aclk,
    input  wire logic     en,
    input  wire pfc_div_t div_in,
    output pfc_div_t      div_out
);

    pfc_div_t         step_next, step_reg;
    logic [REM_W-1:0] trial;

    always_comb begin
        step_next = div_in;
        trial     = '0;
        for (int l = 0; l < NLANE; l++) begin
            trial = (l == LANE_A) ? (REM_W'(div_in.alpha_den) << BIT)
                                  : (REM_W'(div_in.den) << BIT);
            if (div_in.rem[l] >= trial) begin
                step_next.rem[l]      = div_in.rem[l] - trial;
                step_next.quo[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            step_reg <= step_next;
        end
    end

    assign div_out = step_reg;

endmodule

`default_nettype wire

// File: rtl/core/pfc_pack.sv
// Packs the quotients into the destination format, clamps gray, zeroes
// unknown format codes. One register stage. Uses pfc_pkg.
`default_nettype none

module pfc_pack import pfc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       en,
    input  wire pfc_cfg_t   cfg,
    input  wire pfc_div_t   div_in,
    output logic [PIX_W-1:0] pixel_out
);

    logic [NLANE-1:0][QUO_W-1:0] q;
    logic [7:0]                  gray;
    logic [WORD_W-1:0]           lo;
    logic [WORD_W-1:0]           hi;
    logic [PIX_W-1:0]            pixel_next, pixel_reg;

    assign q    = div_in.quo;
    assign gray = (q[LANE_R] > MAX8) ? 8'hFF : q[LANE_R][7:0];

    always_comb begin
        lo = '0;
        hi = '0;
        case (cfg.dst_fmt)
            FMT_GRAY8:  lo = WORD_W'(gray);
            FMT_RGB555: lo = WORD_W'({q[LANE_R][4:0], q[LANE_G][4:0], q[LANE_B][4:0]});
            FMT_RGB565: lo = WORD_W'({q[LANE_R][4:0], q[LANE_G][5:0], q[LANE_B][4:0]});
            FMT_RGB888: lo = WORD_W'({q[LANE_R][7:0], q[LANE_G][7:0], q[LANE_B][7:0]});
            FMT_RGBA8888: begin
                lo = {q[LANE_A][7:0], q[LANE_R][7:0], q[LANE_G][7:0], q[LANE_B][7:0]};
            end
            FMT_RGB16: begin
                lo = {q[LANE_G], q[LANE_R]};
                hi = WORD_W'(q[LANE_B]);
            end
            FMT_RGBA16: begin
                lo = {q[LANE_G], q[LANE_R]};
                hi = {q[LANE_A], q[LANE_B]};
            end
            default: ;
        endcase
        if (cfg.src_fmt > FMT_RGBA16) begin
            lo = '0;
            hi = '0;
        end
        pixel_next = {hi, lo};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel_out = pixel_reg;

endmodule

`default_nettype wire

// File: rtl/core/pixel_format_converter.sv
// Pixel format converter: gray8, RGB555, RGB565, RGB888, RGBA8888, RGB16, RGBA16.
//
// Channels: s_ (source pixel in), m_ (converted pixel out), cfg_ (register writes).
// One pixel per beat on s_tdata/m_tdata; cfg_index selects the register:
// 0 source format, 1 dest format, 2 premultiply enable, 3..5 gray weights
// red, green, blue (Q0.16). Other indexes are ignored. cfg_ready is always high;
// write registers only while no pixel is in flight.
// Pipeline: 5 front stages, 16 division stages, 1 pack stage, output register.
// Throughput: one pixel per cycle while the output buffer is not full; the
// 16-stage restoring divider resolves one quotient bit per stage for all
// channels in parallel.
// Reset clears all valid bits and loads the default registers (RGBA8888 to
// RGBA8888, no premultiply, Rec.709-style gray weights).
// Stall: a two-entry output buffer absorbs the beat in flight; the whole
// pipeline freezes while its second entry is full and s_tready drops.
// No beat is lost or repeated.
// Depends on pfc_pkg, pfc_front, pfc_div_step, pfc_pack.
`default_nettype none

module pixel_format_converter import pfc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // pixel_low[31:0], pixel_high[63:32]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [PIX_W-1:0]           m_tdata,   // result_low[31:0], result_high[63:32]
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    pfc_cfg_t cfg_reg;

    logic [NUM_STAGES-1:0] valid_reg;
    logic                  pipe_en;
    logic                  push;
    logic                  pop;
    logic [PIX_W-1:0]      pack_out;

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [PIX_W-1:0] main_data_reg, main_data_next;
    logic [PIX_W-1:0] skid_data_reg, skid_data_next;

    pfc_div_t div_chain [DIV_STEPS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_fmt <= FMT_RGBA8888;
            cfg_reg.dst_fmt <= FMT_RGBA8888;
            cfg_reg.premul  <= 1'b0;
            cfg_reg.w_red   <= RST_W_RED;
            cfg_reg.w_green <= RST_W_GREEN;
            cfg_reg.w_blue  <= RST_W_BLUE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SRC_FMT: cfg_reg.src_fmt <= pfc_fmt_t'(cfg_data[2:0]);
                CFG_DST_FMT: cfg_reg.dst_fmt <= pfc_fmt_t'(cfg_data[2:0]);
                CFG_PREMUL:  cfg_reg.premul  <= cfg_data[0];
                CFG_W_RED:   cfg_reg.w_red   <= cfg_data;
                CFG_W_GREEN: cfg_reg.w_green <= cfg_data;
                CFG_W_BLUE:  cfg_reg.w_blue  <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe advances while the output buffer has a free second entry
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    pfc_front u_front (
        .aclk    (aclk),
        .en      (pipe_en),
        .cfg     (cfg_reg),
        .pixel   (s_tdata),
        .div_out (div_chain[0])
    );

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        pfc_div_step #(
            .BIT (QUO_W - 1 - s)
        ) u_step (
            .aclk    (aclk),
            .en      (pipe_en),
            .div_in  (div_chain[s]),
            .div_out (div_chain[s+1])
        );
    end

    pfc_pack u_pack (
        .aclk      (aclk),
        .en        (pipe_en),
        .cfg       (cfg_reg),
        .div_in    (div_chain[DIV_STEPS]),
        .pixel_out (pack_out)
    );

    assign push = pipe_en && valid_reg[NUM_STAGES-1];
    assign pop  = main_valid_reg && m_tready;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_valid_next = 1'b1;
                main_data_next  = pack_out;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = pack_out;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/pfc_checker.sv
// Port-level checks for pixel_format_converter, bound to the top level.
// Tracks the destination format from the config channel. Uses pfc_pkg.
`default_nettype none

module pfc_checker import pfc_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [PIX_W-1:0]      m_tdata,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    pfc_fmt_t dst_seen_reg;
    logic     wide_dst;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_seen_reg <= FMT_RGBA8888;
        end else if (cfg_valid && cfg_ready && cfg_index == CFG_DST_FMT) begin
            dst_seen_reg <= pfc_fmt_t'(cfg_data[2:0]);
        end
    end

    assign wide_dst = (dst_seen_reg == FMT_RGB16) || (dst_seen_reg == FMT_RGBA16);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_high_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !wide_dst && !s_tvalid |-> m_tdata[PIX_W-1:WORD_W] == '0)
        else $error("result_high nonzero for narrow destination");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (.*);

`default_nettype wire
